FILE: src/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg: shared types and constants for the stream pattern replace core
// Byte-lane geometry, length and count widths, and configuration register codes.
// ----------------------------------------------------------------------------
package spr_pkg;

	localparam int BYTE_W    = 8;
	localparam int LANES     = 8;
	localparam int WORD_W    = BYTE_W * LANES;
	localparam int CNT_W     = 3;
	localparam int LEN_W     = 4;
	localparam int CFG_IDX_W = 4;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [LEN_W-1:0]  len_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MATCH_LENGTH   = 4'd0,
		REG_MATCH_TEXT     = 4'd1,
		REG_REPLACE_LENGTH = 4'd2,
		REG_REPLACE_TEXT   = 4'd3
	} cfg_reg_t;

endpackage

FILE: src/spr_in_if.sv
// ----------------------------------------------------------------------------
// spr_in_if: input byte channel
// Valid/ready channel carrying one raw stream byte and its end-of-stream mark.
// ----------------------------------------------------------------------------
interface spr_in_if;
	logic          valid;
	logic          ready;
	spr_pkg::byte_t in_byte;
	logic          stream_end;

	modport source (output valid, output in_byte, output stream_end, input ready);
	modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

FILE: src/spr_out_if.sv
// ----------------------------------------------------------------------------
// spr_out_if: output byte channel
// Valid/ready channel carrying one filtered byte and its end-of-run mark.
// ----------------------------------------------------------------------------
interface spr_out_if;
	logic          valid;
	logic          ready;
	spr_pkg::byte_t out_byte;
	logic          run_last;

	modport source (output valid, output out_byte, output run_last, input ready);
	modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

FILE: src/spr_cfg_if.sv
// ----------------------------------------------------------------------------
// spr_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface spr_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [spr_pkg::CFG_IDX_W-1:0]     index;
	spr_pkg::word_t                    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/stream_pattern_replace_core.sv
// ----------------------------------------------------------------------------
// stream_pattern_replace_core: streaming byte search and replace
// Replaces occurrences of a programmed pattern with a programmed replacement,
// one input byte per cycle unless the output burst register stalls the input.
// ----------------------------------------------------------------------------
// Usage: program match_length/match_text/replace_length/replace_text through
// cfg while the core is idle, then stream bytes in. Each input byte yields
// between zero and eight output bytes; run_last marks the final output byte
// that an input byte caused. A partially matched prefix is held internally as
// a count only and replayed from match_text on a mismatch (followed by the
// mismatching byte, which is not re-examined as a new match start) or flushed
// when stream_end is set. Throughput: an input byte is taken every cycle as
// long as each one produces at most one output byte and the output is ready;
// an input byte that produces more than one output byte blocks the input until
// the single-byte output port drains the burst register, one byte per cycle
// while filtered.ready is high. Output is registered. cfg.ready is always high.
// ----------------------------------------------------------------------------
module stream_pattern_replace_core #(
	parameter int MAX_LEN = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	spr_cfg_if.sink   cfg,
	spr_in_if.sink    stream,
	spr_out_if.source filtered
);

	localparam int LANE_SEL_W = $clog2(spr_pkg::LANES);

	// Configuration registers
	spr_pkg::len_t  match_length_q;
	spr_pkg::word_t match_text_q;
	spr_pkg::len_t  replace_length_q;
	spr_pkg::word_t replace_text_q;

	// Match state: number of pattern bytes held
	spr_pkg::cnt_t  cnt_q;

	// Result stage: burst of output bytes built for one input byte
	spr_pkg::word_t burst_data_s1;
	spr_pkg::len_t  burst_len_s1;
	logic [LANE_SEL_W-1:0] idx_q;

	spr_pkg::len_t  mlen;
	spr_pkg::len_t  rlen;
	spr_pkg::len_t  cnt_ext;
	spr_pkg::len_t  cnt_inc;
	spr_pkg::byte_t pat_byte;
	logic           hit;
	logic           complete;
	logic           busy;
	logic           take;
	logic           last_take;
	logic           accept;
	spr_pkg::word_t burst_word;
	spr_pkg::len_t  burst_len;
	spr_pkg::cnt_t  cnt_next;

	// ------------------------------------------------------------------
	// Configuration writes: always ready, unknown indexes are dropped.
	// ------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_length_q   <= spr_pkg::len_t'(1);
			match_text_q     <= '0;
			replace_length_q <= '0;
			replace_text_q   <= '0;
		end else if (cfg.valid) begin
			unique case (spr_pkg::cfg_reg_t'(cfg.index))
				spr_pkg::REG_MATCH_LENGTH:   match_length_q   <= cfg.data[spr_pkg::LEN_W-1:0];
				spr_pkg::REG_MATCH_TEXT:     match_text_q     <= cfg.data;
				spr_pkg::REG_REPLACE_LENGTH: replace_length_q <= cfg.data[spr_pkg::LEN_W-1:0];
				spr_pkg::REG_REPLACE_TEXT:   replace_text_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Effective lengths: a zero pattern length acts as one, anything above
	// MAX_LEN is clamped to MAX_LEN.
	// ------------------------------------------------------------------
	always_comb begin
		if (match_length_q == '0)
			mlen = spr_pkg::len_t'(1);
		else if (match_length_q > spr_pkg::len_t'(MAX_LEN))
			mlen = spr_pkg::len_t'(MAX_LEN);
		else
			mlen = match_length_q;

		if (replace_length_q > spr_pkg::len_t'(MAX_LEN))
			rlen = spr_pkg::len_t'(MAX_LEN);
		else
			rlen = replace_length_q;
	end

	// ------------------------------------------------------------------
	// Match decision for the byte on the input channel.
	// ------------------------------------------------------------------
	assign cnt_ext  = {1'b0, cnt_q};
	assign cnt_inc  = cnt_ext + spr_pkg::len_t'(1);
	assign pat_byte = match_text_q[cnt_q*spr_pkg::BYTE_W +: spr_pkg::BYTE_W];
	assign hit      = (cnt_ext < mlen) && (stream.in_byte == pat_byte);
	assign complete = hit && (cnt_inc >= mlen);

	// Build the burst: replacement on a full match, held prefix plus the byte on
	// a mismatch, held prefix plus the matching byte on an end-of-stream flush.
	always_comb begin
		burst_word = '0;
		burst_len  = '0;
		cnt_next   = '0;
		if (complete) begin
			burst_word = replace_text_q;
			burst_len  = rlen;
		end else if (hit) begin
			if (stream.stream_end) begin
				for (int i = 0; i < spr_pkg::LANES; i++) begin
					if (spr_pkg::len_t'(i) < cnt_inc)
						burst_word[i*spr_pkg::BYTE_W +: spr_pkg::BYTE_W] =
							match_text_q[i*spr_pkg::BYTE_W +: spr_pkg::BYTE_W];
				end
				burst_len = cnt_inc;
			end else begin
				cnt_next = cnt_inc[spr_pkg::CNT_W-1:0];
			end
		end else begin
			for (int i = 0; i < spr_pkg::LANES; i++) begin
				if (spr_pkg::len_t'(i) < cnt_ext)
					burst_word[i*spr_pkg::BYTE_W +: spr_pkg::BYTE_W] =
						match_text_q[i*spr_pkg::BYTE_W +: spr_pkg::BYTE_W];
				else if (spr_pkg::len_t'(i) == cnt_ext)
					burst_word[i*spr_pkg::BYTE_W +: spr_pkg::BYTE_W] = stream.in_byte;
			end
			burst_len = cnt_inc;
		end
	end

	// ------------------------------------------------------------------
	// Handshakes: take a new input byte when the burst register is empty or
	// its last byte leaves in this cycle.
	// ------------------------------------------------------------------
	assign busy      = (burst_len_s1 != '0);
	assign take      = filtered.valid && filtered.ready;
	assign last_take = take && filtered.run_last;
	assign stream.ready = !busy || last_take;
	assign accept    = stream.valid && stream.ready;

	assign filtered.valid    = busy;
	assign filtered.out_byte = burst_data_s1[idx_q*spr_pkg::BYTE_W +: spr_pkg::BYTE_W];
	assign filtered.run_last = ({1'b0, idx_q} == (burst_len_s1 - spr_pkg::len_t'(1)));

	// Advance the match count on every accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= cnt_next;
		end
	end

	// Load a new burst on accept, else step through the held one; clear the
	// length once its last byte is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_len_s1 <= '0;
			idx_q        <= '0;
		end else if (accept) begin
			burst_len_s1 <= burst_len;
			idx_q        <= '0;
		end else if (last_take) begin
			burst_len_s1 <= '0;
			idx_q        <= '0;
		end else if (take) begin
			idx_q <= idx_q + LANE_SEL_W'(1);
		end
	end

	// Burst payload carries no reset
	always_ff @(posedge clk) begin
		if (accept)
			burst_data_s1 <= burst_word;
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_burst_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		burst_len_s1 <= spr_pkg::len_t'(spr_pkg::LANES))
		else $error("burst length above lane count");

	a_idx_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> ({1'b0, idx_q} < burst_len_s1))
		else $error("burst index beyond burst length");

	a_ready_only_on_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && stream.ready) |-> (filtered.ready && filtered.run_last))
		else $error("input taken while burst still pending");

	a_mismatch_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !hit) |=> busy)
		else $error("mismatch produced no output");

	a_end_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && stream.stream_end) |=> (cnt_q == '0))
		else $error("match count held past end of stream");

endmodule
